>>> hdl/tfc_pkg.sv
// Shared types and constants for the thermal fan controller.
package tfc_pkg;

    // Fault counter limits and stable-detection run length
    localparam int unsigned CNT_W = 8;
    localparam logic [CNT_W-1:0] SENSOR_FAULT_LIMIT = 8'd8;
    localparam logic [CNT_W-1:0] FAN_FAULT_LIMIT    = 8'd8;

    localparam int unsigned EQ_W = 5;
    localparam logic [EQ_W-1:0] STABLE_TICKS = 5'd16;

    // Temperatures are Q8.2, so one degree is four LSBs
    localparam int unsigned TEMP_W = 10;
    localparam logic [TEMP_W:0] QUARTERS_PER_DEG = 11'd4;

    localparam int unsigned DUTY_W = 8;
    localparam int unsigned MODE_W = 2;

    // Mode codes as seen on the result stream
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REG    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STABLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OTP    = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DEG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DEG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OTP_ON_DEG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OTP_OFF_DEG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SLOPE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DUTY   = 3'd7;

    localparam int unsigned SLOPE_W = 6;

    typedef struct packed {
        logic [7:0]         start_deg;
        logic [7:0]         stop_deg;
        logic [7:0]         otp_on_deg;
        logic [7:0]         otp_off_deg;
        logic [SLOPE_W-1:0] duty_slope;
        logic [DUTY_W-1:0]  min_duty;
        logic [DUTY_W-1:0]  max_duty;
        logic [DUTY_W-1:0]  idle_duty;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        start_deg:   8'd40,
        stop_deg:    8'd35,
        otp_on_deg:  8'd100,
        otp_off_deg: 8'd70,
        duty_slope:  6'd4,
        min_duty:    8'd20,
        max_duty:    8'd255,
        idle_duty:   8'd0
    };

    // Result of one control step
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [MODE_W-1:0] mode;
        logic              otp;
    } t_ctrl;

endpackage

>>> hdl/tfc_leak_counter.sv
// Leaky fault counter: counts up on fault, down otherwise, pulses at the limit.
module tfc_leak_counter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_fault,
    input  logic [tfc_pkg::CNT_W-1:0] i_limit,
    output logic                      o_pulse
);

    logic [tfc_pkg::CNT_W-1:0] r_cnt;
    logic [tfc_pkg::CNT_W-1:0] n_cnt;
    logic [tfc_pkg::CNT_W-1:0] w_inc;

    assign w_inc = r_cnt + 1'b1;  // wraps at 8 bits

    always_comb begin
        n_cnt   = r_cnt;
        o_pulse = 1'b0;
        if (i_fault) begin
            if (w_inc == i_limit) begin
                n_cnt   = i_limit - 1'b1;
                o_pulse = 1'b1;
            end else begin
                n_cnt = w_inc;
            end
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_en) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> hdl/tfc_mode_fsm.sv
// Mode state machine with duty ramp, stable detection and overtemperature.
module tfc_mode_fsm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [tfc_pkg::TEMP_W-1:0]  i_hot,
    input  tfc_pkg::t_cfg               i_cfg,
    output logic [tfc_pkg::DUTY_W-1:0]  o_duty_cur,
    output tfc_pkg::t_ctrl              o_next
);

    typedef enum logic [tfc_pkg::MODE_W-1:0] {
        ST_IDLE   = tfc_pkg::MODE_IDLE,
        ST_REG    = tfc_pkg::MODE_REG,
        ST_STABLE = tfc_pkg::MODE_STABLE,
        ST_OTP    = tfc_pkg::MODE_OTP
    } t_state;

    t_state                         r_state, n_state;
    logic [tfc_pkg::DUTY_W-1:0]     r_duty, n_duty;
    logic [tfc_pkg::EQ_W-1:0]       r_eq_cnt, n_eq_cnt;
    logic [tfc_pkg::TEMP_W-1:0]     r_held, n_held;
    logic                           w_otp;

    // Thresholds in quarter degrees (11 bits, unsigned)
    logic [tfc_pkg::TEMP_W:0]       w_hot;
    logic [tfc_pkg::TEMP_W:0]       w_start_q, w_stop_q, w_on_q, w_off_q;
    logic signed [tfc_pkg::TEMP_W+1:0] w_diff;
    logic signed [17:0]             w_prod;
    logic signed [17:0]             w_p;
    logic signed [17:0]             w_min_s, w_max_s;
    logic [tfc_pkg::DUTY_W-1:0]     w_ramp;
    logic [tfc_pkg::EQ_W-1:0]       w_eq_inc;

    assign w_hot     = {1'b0, i_hot};
    assign w_start_q = {1'b0, i_cfg.start_deg, 2'b00};
    assign w_stop_q  = {1'b0, i_cfg.stop_deg, 2'b00};
    assign w_on_q    = {1'b0, i_cfg.otp_on_deg, 2'b00};
    assign w_off_q   = {1'b0, i_cfg.otp_off_deg, 2'b00};

    // Linear ramp: slope * (hot - start) + min, then clamp
    assign w_diff  = $signed({1'b0, w_hot}) - $signed({1'b0, w_start_q});
    // both operands widened to 18 bits so the product keeps its top bits
    assign w_prod  = $signed({{6{w_diff[tfc_pkg::TEMP_W+1]}}, w_diff}) *
                     $signed({12'b0, i_cfg.duty_slope});
    assign w_min_s = $signed({10'b0, i_cfg.min_duty});
    assign w_max_s = $signed({10'b0, i_cfg.max_duty});
    assign w_p     = w_prod + w_min_s;

    always_comb begin
        if (w_p < w_min_s) begin
            w_ramp = i_cfg.min_duty;
        end else if (w_p > w_max_s) begin
            w_ramp = i_cfg.max_duty;
        end else begin
            w_ramp = w_p[tfc_pkg::DUTY_W-1:0];
        end
    end

    assign w_eq_inc = r_eq_cnt + 1'b1;

    always_comb begin
        n_state  = r_state;
        n_duty   = r_duty;
        n_eq_cnt = r_eq_cnt;
        n_held   = r_held;
        w_otp    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_hot >= w_start_q) begin
                    n_state = ST_REG;
                end
            end
            ST_REG: begin
                n_duty = w_ramp;
                if (w_ramp == r_duty) begin
                    n_eq_cnt = w_eq_inc;
                    if (w_eq_inc == tfc_pkg::STABLE_TICKS) begin
                        n_eq_cnt = '0;
                        n_held   = i_hot;
                        n_state  = ST_STABLE;
                    end
                end else begin
                    n_eq_cnt = '0;
                end
                // protection and idle override the stable entry
                if (w_hot >= w_on_q) begin
                    w_otp   = 1'b1;
                    n_state = ST_OTP;
                    n_duty  = i_cfg.max_duty;
                end else if (w_hot <= w_stop_q) begin
                    n_duty  = i_cfg.idle_duty;
                    n_state = ST_IDLE;
                end
            end
            ST_STABLE: begin
                // lower bound written as hot + 4 <= held so it never wraps
                if ((w_hot >= ({1'b0, r_held} + tfc_pkg::QUARTERS_PER_DEG)) ||
                    ((w_hot + tfc_pkg::QUARTERS_PER_DEG) <= {1'b0, r_held})) begin
                    n_state = ST_REG;
                end
            end
            ST_OTP: begin
                if (w_hot <= w_off_q) begin
                    n_state = ST_REG;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_duty   <= tfc_pkg::CFG_RESET.idle_duty;
            r_eq_cnt <= '0;
            r_held   <= '0;
        end else if (i_en) begin
            r_state  <= n_state;
            r_duty   <= n_duty;
            r_eq_cnt <= n_eq_cnt;
            r_held   <= n_held;
        end
    end

    assign o_duty_cur  = r_duty;
    assign o_next.duty = n_duty;
    assign o_next.mode = n_state;
    assign o_next.otp  = w_otp;

endmodule

>>> hdl/thermal_fan_controller_top.sv
// Top level of the thermal fan controller: stream ports, config, pipeline.
//
//  Channel  | Direction | Handshake                      | Contents
//  ---------+-----------+--------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | one tick: temps, rpms, bad flags
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | one result per tick
//  cfg      | in        | i_cfg_we (no wait)             | 8-bit register write
//
// One tick per cycle sustained while m_axis_tready is high. A tick is
// held in the input register, then the control step (one 12x7 multiply,
// clamp, state update) runs into the output register, which drives m_axis.
// Fault counters and mode state advance only when a tick moves into the output
// register, so stalls on m_axis simply hold both stages; s_axis_tready drops
// only when both stages are full and the output is not being taken.
// Reset (i_rst_n low, synchronous) empties both stages and loads config
// defaults; the duty starts at the default idle duty.
module thermal_fan_controller_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [9:0] temp_left, [19:10] temp_right, [35:20] fan_one_rpm,
    // [51:36] fan_two_rpm, [55:52] zero
    input  logic [55:0]                        s_axis_tdata,
    // [0] left_bad, [1] right_bad
    input  logic [1:0]                         s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] fan_duty_out, [9:8] mode_out, [10] left_sensor_fault,
    // [11] right_sensor_fault, [12] fan_one_fault, [13] fan_two_fault,
    // [14] otp_fault, [22:15] left_deg, [30:23] right_deg, [31] zero
    output logic [31:0]                        m_axis_tdata,

    input  logic                               i_cfg_we,
    input  logic [tfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tfc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // ---------------- configuration registers ----------------
    tfc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tfc_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tfc_pkg::CFG_START_DEG:   r_cfg.start_deg   <= i_cfg_data;
                tfc_pkg::CFG_STOP_DEG:    r_cfg.stop_deg    <= i_cfg_data;
                tfc_pkg::CFG_OTP_ON_DEG:  r_cfg.otp_on_deg  <= i_cfg_data;
                tfc_pkg::CFG_OTP_OFF_DEG: r_cfg.otp_off_deg <= i_cfg_data;
                tfc_pkg::CFG_DUTY_SLOPE:
                    r_cfg.duty_slope <= i_cfg_data[tfc_pkg::SLOPE_W-1:0];
                tfc_pkg::CFG_MIN_DUTY:    r_cfg.min_duty    <= i_cfg_data;
                tfc_pkg::CFG_MAX_DUTY:    r_cfg.max_duty    <= i_cfg_data;
                tfc_pkg::CFG_IDLE_DUTY:   r_cfg.idle_duty   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- input stage ----------------
    logic                           r_in_valid;
    logic [tfc_pkg::TEMP_W-1:0]     r_temp_l, r_temp_r;
    logic                           r_bad_l, r_bad_r;
    logic [15:0]                    r_rpm1, r_rpm2;
    logic                           r_out_valid;
    logic [31:0]                    r_out_tdata;
    logic                           w_adv;   // tick moves into output register

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_temp_l <= s_axis_tdata[9:0];
            r_temp_r <= s_axis_tdata[19:10];
            r_rpm1   <= s_axis_tdata[35:20];
            r_rpm2   <= s_axis_tdata[51:36];
            r_bad_l  <= s_axis_tuser[0];
            r_bad_r  <= s_axis_tuser[1];
        end
    end

    // ---------------- control step ----------------
    logic [tfc_pkg::TEMP_W-1:0]     w_tl, w_tr, w_hot;
    logic [tfc_pkg::DUTY_W-1:0]     w_duty_cur;
    logic                           w_fan_on;
    logic                           w_lf, w_rf, w_f1, w_f2;
    tfc_pkg::t_ctrl                 w_ctrl;

    // a sensor flagged bad reads as zero
    assign w_tl  = r_bad_l ? '0 : r_temp_l;
    assign w_tr  = r_bad_r ? '0 : r_temp_r;
    assign w_hot = (w_tl > w_tr) ? w_tl : w_tr;

    // fan check uses the duty in force before this tick
    assign w_fan_on = w_duty_cur > r_cfg.min_duty;

    tfc_leak_counter u_cnt_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_fault (r_bad_l),
        .i_limit (tfc_pkg::SENSOR_FAULT_LIMIT),
        .o_pulse (w_lf)
    );

    tfc_leak_counter u_cnt_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_fault (r_bad_r),
        .i_limit (tfc_pkg::SENSOR_FAULT_LIMIT),
        .o_pulse (w_rf)
    );

    tfc_leak_counter u_cnt_fan1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_fault (w_fan_on && (r_rpm1 == '0)),
        .i_limit (tfc_pkg::FAN_FAULT_LIMIT),
        .o_pulse (w_f1)
    );

    tfc_leak_counter u_cnt_fan2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_fault (w_fan_on && (r_rpm2 == '0)),
        .i_limit (tfc_pkg::FAN_FAULT_LIMIT),
        .o_pulse (w_f2)
    );

    tfc_mode_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_hot      (w_hot),
        .i_cfg      (r_cfg),
        .o_duty_cur (w_duty_cur),
        .o_next     (w_ctrl)
    );

    // ---------------- output stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_tdata <= {1'b0,
                            w_tr[tfc_pkg::TEMP_W-1:2],
                            w_tl[tfc_pkg::TEMP_W-1:2],
                            w_ctrl.otp, w_f2, w_f1, w_rf, w_lf,
                            w_ctrl.mode,
                            w_ctrl.duty};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

endmodule
